[hw/rtl/rrc_pkg.sv]
// shared types and constants for the rolling return correlation block
`default_nettype none

package rrc_pkg;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_ZERO, OP_MSB, OP_NORM, OP_SQUARE, OP_DIFF, OP_RET, OP_GRAB,
      OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_DIV_LOAD, OP_DIV_STEP, OP_DIV_STORE,
      OP_M1, OP_M2, OP_M3, OP_M4, OP_SQRT_LOAD, OP_SQRT_STEP, OP_SQRT_STORE,
      OP_DMUL, OP_FRAC, OP_EMIT
   } op_type;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE, ST_SORT, ST_ZERO, ST_MSB, ST_NORM, ST_SQUARE, ST_DIFF, ST_RET, ST_READ,
      ST_GRAB, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_CHECK, ST_DIV_LOAD, ST_DIV_STEP,
      ST_DIV_STORE, ST_M1, ST_M2, ST_M3, ST_M4, ST_FLOOR, ST_SQRT_LOAD, ST_SQRT_STEP,
      ST_SQRT_STORE, ST_DMUL, ST_FRAC, ST_EMIT
   } state_type;

   // operand selects for the divider and the square root
   localparam logic [2:0] DIV_MEAN_FIRST  = 3'd0;
   localparam logic [2:0] DIV_MEAN_SECOND = 3'd1;
   localparam logic [2:0] DIV_VAR_FIRST   = 3'd2;
   localparam logic [2:0] DIV_VAR_SECOND  = 3'd3;
   localparam logic [2:0] DIV_COV         = 3'd4;
   localparam logic [2:0] SQ_FIRST        = 3'd0;
   localparam logic [2:0] SQ_SECOND       = 3'd1;

   // configuration register indexes
   localparam logic [1:0] REG_CORR_HIGH      = 2'd0;
   localparam logic [1:0] REG_CORR_LOW       = 2'd1;
   localparam logic [1:0] REG_VARIANCE_FLOOR = 2'd2;

   // ln 2 in Q30
   localparam logic [31:0] LN2_Q30 = 32'd744261118;

   // command from controller to datapath
   typedef struct packed {
      op_type     op;
      logic [4:0] cnt;
      logic [2:0] sel;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic ignored;
      logic price_zero;
      logic seen;
      logic full_both;
      logic var_low;
      logic busy;
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/rrc_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module rrc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hw/rtl/rrc_ctrl.sv]
// sequencing state machine for the rolling return correlation block
`default_nettype none

module rrc_ctrl
   import rrc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [2:0] sel_ff, sel_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      sel_in     = sel_ff;
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.cnt    = cnt_ff;
      cmd.sel    = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            if (status.ignored) begin
               state_in = ST_CHECK;
            end else if (status.price_zero) begin
               state_in = ST_ZERO;
            end else begin
               state_in = ST_MSB;
               cnt_in   = 5'd5;
            end
         end
         ST_ZERO: begin
            cmd.op   = OP_ZERO;
            state_in = ST_READ;
         end
         ST_MSB: begin
            cmd.op = OP_MSB;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.op   = OP_NORM;
            state_in = ST_SQUARE;
            cnt_in   = 5'd23;
         end
         ST_SQUARE: begin
            cmd.op = OP_SQUARE;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = status.seen ? ST_RET : ST_READ;
         end
         ST_RET: begin
            cmd.op   = OP_RET;
            state_in = ST_READ;
         end
         ST_READ: state_in = ST_GRAB;
         ST_GRAB: begin
            cmd.op   = OP_GRAB;
            state_in = ST_P1;
         end
         ST_P1: begin
            cmd.op   = OP_P1;
            state_in = ST_P2;
         end
         ST_P2: begin
            cmd.op   = OP_P2;
            state_in = ST_P3;
         end
         ST_P3: begin
            cmd.op   = OP_P3;
            state_in = ST_P4;
         end
         ST_P4: begin
            cmd.op   = OP_P4;
            state_in = ST_P5;
         end
         ST_P5: begin
            cmd.op   = OP_P5;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.full_both) begin
               state_in = ST_DIV_LOAD;
               sel_in   = DIV_MEAN_FIRST;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_LOAD: begin
            cmd.op   = OP_DIV_LOAD;
            state_in = ST_DIV_STEP;
            cnt_in   = 5'd7;
         end
         ST_DIV_STEP: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_DIV_STORE;
            end
         end
         ST_DIV_STORE: begin
            cmd.op = OP_DIV_STORE;
            if (sel_ff == DIV_COV) begin
               state_in = ST_M1;
            end else begin
               state_in = ST_DIV_LOAD;
               sel_in   = sel_ff + 3'd1;
            end
         end
         ST_M1: begin
            cmd.op   = OP_M1;
            state_in = ST_M2;
         end
         ST_M2: begin
            cmd.op   = OP_M2;
            state_in = ST_M3;
         end
         ST_M3: begin
            cmd.op   = OP_M3;
            state_in = ST_M4;
         end
         ST_M4: begin
            cmd.op   = OP_M4;
            state_in = ST_FLOOR;
         end
         ST_FLOOR: begin
            if (status.var_low) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SQRT_LOAD;
               sel_in   = SQ_FIRST;
            end
         end
         ST_SQRT_LOAD: begin
            cmd.op   = OP_SQRT_LOAD;
            state_in = ST_SQRT_STEP;
            cnt_in   = 5'd31;
         end
         ST_SQRT_STEP: begin
            cmd.op = OP_SQRT_STEP;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_SQRT_STORE;
            end
         end
         ST_SQRT_STORE: begin
            cmd.op = OP_SQRT_STORE;
            if (sel_ff == SQ_SECOND) begin
               state_in = ST_DMUL;
            end else begin
               state_in = ST_SQRT_LOAD;
               sel_in   = SQ_SECOND;
            end
         end
         ST_DMUL: begin
            cmd.op   = OP_DMUL;
            state_in = ST_FRAC;
            cnt_in   = 5'd14;
         end
         ST_FRAC: begin
            cmd.op = OP_FRAC;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.busy) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/rrc_datapath.sv]
// return rings, running sums and the shared arithmetic units
`default_nettype none

module rrc_datapath
   import rrc_pkg::*;
#(
   parameter int WINDOW_LEN = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   output status_type        status,
   input  wire logic [127:0] req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         csr_valid,
   input  wire logic [1:0]   csr_index,
   input  wire logic [40:0]  csr_data,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [79:0]  rsp_tdata,
   output logic      [0:0]   rsp_tuser
);

   localparam int HW = $clog2(WINDOW_LEN);
   localparam int FW = $clog2(WINDOW_LEN + 1);
   localparam logic [FW-1:0] WIN_FILL = FW'(WINDOW_LEN);
   localparam logic [FW:0]   WIN_DIV  = (FW + 1)'(WINDOW_LEN);
   localparam logic [HW-1:0] HEAD_LAST = HW'(WINDOW_LEN - 1);

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (32'd0 - v) : v;
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] v);
      mag64 = v[63] ? (64'd0 - v) : v;
   endfunction

   // configuration
   logic signed [15:0] cfg_high_ff, cfg_low_ff;
   logic [40:0]        cfg_floor_ff;

   // item and log2
   logic [1:0]         asset_ff;
   logic [62:0]        price_ff, time_ff;
   logic [5:0]         msb_ff;
   logic [31:0]        m_ff;
   logic [23:0]        frac_ff;
   logic signed [32:0] diff_ff;
   logic [31:0]        ret_ff;

   // per asset state
   logic               seen_ff [2];
   logic [31:0]        last_ff [2];
   logic [HW-1:0]      head_ff [2];
   logic [FW-1:0]      fill_ff [2];

   // window sums
   logic [31:0]        old_ff, oth_ff;
   logic [63:0]        sum1_ff, sum2_ff, sq1_ff, sq2_ff, cross_ff, pq_ff;

   // statistics
   logic [63:0]        div_num_ff;
   logic [FW-1:0]      div_rem_ff;
   logic               div_neg_ff;
   logic [31:0]        mx_ff, my_ff;
   logic signed [63:0] vx_ff, vy_ff, cov_ff;
   logic [63:0]        sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [31:0]        sigx_ff, sigy_ff;
   logic [63:0]        d_ff, fr_ff;
   logic [14:0]        fq_ff;
   logic               ip_ff, cneg_ff;

   // result register
   logic               rsp_valid_ff, rsp_dir_ff;
   logic [62:0]        rsp_time_ff;
   logic [15:0]        rsp_corr_ff;

   logic               a, ob;
   logic [31:0]        rd0, rd1, ua, ub, own_rd, oth_rd, new_last, dmag;
   logic               psign;
   logic [63:0]        mul_out, pmag, pq_in, rnd, div_src, div_q, sq_sum;
   logic [33:0]        rmag;
   logic [31:0]        ret_in, cur_log, q_clamp;
   logic [32:0]        sq_t;
   logic [5:0]         msb_cand;
   logic [62:0]        norm_w;
   logic [63:0]        div_num_in;
   logic [FW-1:0]      div_rem_in;
   logic [64:0]        fr2;
   logic signed [15:0] corr_val;
   logic               emit_hit, d_zero;
   logic [63:0]        cov_abs;

   assign a  = asset_ff[0];
   assign ob = ~asset_ff[0];

   // return rings
   rrc_ram #(.WIDTH(32), .DEPTH(WINDOW_LEN)) u_ring0 (
      .clock   (clock),
      .wr_en   (cmd.op == OP_P5 && !a),
      .wr_addr (head_ff[a]),
      .wr_data (ret_ff),
      .rd_addr (head_ff[a]),
      .rd_data (rd0)
   );

   rrc_ram #(.WIDTH(32), .DEPTH(WINDOW_LEN)) u_ring1 (
      .clock   (clock),
      .wr_en   (cmd.op == OP_P5 && a),
      .wr_addr (head_ff[a]),
      .wr_data (ret_ff),
      .rd_addr (head_ff[a]),
      .rd_data (rd1)
   );

   assign own_rd = a ? rd1 : rd0;
   assign oth_rd = a ? rd0 : rd1;

   // shared multiplier operand select
   always_comb begin
      ua    = '0;
      ub    = '0;
      psign = 1'b0;
      case (cmd.op)
         OP_SQUARE: begin
            ua = m_ff;
            ub = m_ff;
         end
         OP_RET: begin
            ua = dmag;
            ub = LN2_Q30;
         end
         OP_P1: begin
            ua = mag32(old_ff);
            ub = mag32(old_ff);
         end
         OP_P2: begin
            ua = mag32(ret_ff);
            ub = mag32(ret_ff);
         end
         OP_P3: begin
            ua    = mag32(old_ff);
            ub    = mag32(oth_ff);
            psign = old_ff[31] ^ oth_ff[31];
         end
         OP_P4: begin
            ua    = mag32(ret_ff);
            ub    = mag32(oth_ff);
            psign = ret_ff[31] ^ oth_ff[31];
         end
         OP_M1: begin
            ua = mag32(mx_ff);
            ub = mag32(mx_ff);
         end
         OP_M2: begin
            ua = mag32(my_ff);
            ub = mag32(my_ff);
         end
         OP_M3: begin
            ua    = mag32(mx_ff);
            ub    = mag32(my_ff);
            psign = mx_ff[31] ^ my_ff[31];
         end
         OP_DMUL: begin
            ua = sigx_ff;
            ub = sigy_ff;
         end
         default: ;
      endcase
   end

   assign mul_out = {32'd0, ua} * {32'd0, ub};
   assign pmag    = {8'd0, mul_out[63:8]};
   assign pq_in   = psign ? (64'd0 - pmag) : pmag;

   // log2 helpers
   assign msb_cand = msb_ff | (6'd1 << cmd.cnt[2:0]);
   assign norm_w   = (msb_ff >= 6'd31) ? (price_ff >> (msb_ff - 6'd31))
                                       : (price_ff << (6'd31 - msb_ff));
   assign sq_t     = mul_out[63:31];
   assign cur_log  = {2'b00, msb_ff, frac_ff};
   assign new_last = cur_log;

   // rounded and saturated return
   assign dmag = diff_ff[32] ? 32'(33'sd0 - diff_ff) : diff_ff[31:0];
   assign rnd  = mul_out + (64'd1 << 29);
   assign rmag = rnd[63:30];
   always_comb begin
      if (diff_ff[32]) begin
         ret_in = (rmag > 34'h080000000) ? 32'h80000000 : (32'd0 - rmag[31:0]);
      end else begin
         ret_in = (rmag > 34'h07fffffff) ? 32'h7fffffff : rmag[31:0];
      end
   end

   // divide by the window length, eight quotient bits a step
   always_comb begin
      logic [FW:0]   t;
      logic [FW-1:0] r;
      logic [7:0]    q;
      r = div_rem_ff;
      q = '0;
      for (int k = 0; k < 8; k++) begin
         t = {r, div_num_ff[63 - k]};
         if (t >= WIN_DIV) begin
            t    = t - WIN_DIV;
            q[7 - k] = 1'b1;
         end
         r = t[FW-1:0];
      end
      div_rem_in = r;
      div_num_in = {div_num_ff[55:0], q};
   end

   always_comb begin
      case (cmd.sel)
         DIV_MEAN_FIRST:  div_src = sum1_ff;
         DIV_MEAN_SECOND: div_src = sum2_ff;
         DIV_VAR_FIRST:   div_src = sq1_ff;
         DIV_VAR_SECOND:  div_src = sq2_ff;
         default:         div_src = cross_ff;
      endcase
   end

   assign div_q   = div_neg_ff ? (64'd0 - div_num_ff) : div_num_ff;
   assign q_clamp = (div_q[63:31] == '0 || div_q[63:31] == '1) ? div_q[31:0]
                  : (div_q[63] ? 32'h80000000 : 32'h7fffffff);

   // square root and fraction steps
   assign sq_sum  = sq_res_ff + sq_bit_ff;
   assign fr2     = {fr_ff, 1'b0};
   assign cov_abs = mag64(cov_ff);

   // final correlation and threshold test
   assign d_zero = (d_ff == 64'd0);
   always_comb begin
      if (ip_ff) begin
         corr_val = cneg_ff ? 16'sh8000 : 16'sh7fff;
      end else begin
         corr_val = cneg_ff ? -$signed({1'b0, fq_ff}) : $signed({1'b0, fq_ff});
      end
   end
   assign emit_hit = !d_zero && (corr_val > cfg_high_ff || corr_val < cfg_low_ff);

   // status to the controller
   assign status.ignored    = asset_ff[1];
   assign status.price_zero = (price_ff == '0);
   assign status.seen       = seen_ff[a];
   assign status.full_both  = (fill_ff[0] == WIN_FILL) && (fill_ff[1] == WIN_FILL);
   assign status.var_low    = (vx_ff < $signed({23'd0, cfg_floor_ff}))
                           || (vy_ff < $signed({23'd0, cfg_floor_ff}));
   assign status.busy       = rsp_valid_ff && !rsp_tready;

   // control state, sums and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_high_ff  <= 16'sd26214;
         cfg_low_ff   <= -16'sd26214;
         cfg_floor_ff <= 41'd1;
         for (int i = 0; i < 2; i++) begin
            seen_ff[i] <= 1'b0;
            last_ff[i] <= '0;
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         sum1_ff      <= '0;
         sum2_ff      <= '0;
         sq1_ff       <= '0;
         sq2_ff       <= '0;
         cross_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // configuration write transaction
         if (csr_valid) begin
            unique case (csr_index)
               REG_CORR_HIGH:      cfg_high_ff  <= csr_data[15:0];
               REG_CORR_LOW:       cfg_low_ff   <= csr_data[15:0];
               REG_VARIANCE_FLOOR: cfg_floor_ff <= csr_data;
               default: ;
            endcase
         end
         // result valid: raised on a hit, dropped once the transaction is taken
         if (cmd.op == OP_EMIT && emit_hit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_ZERO: begin
               seen_ff[a] <= 1'b0;
               last_ff[a] <= '0;
            end
            OP_DIFF: begin
               seen_ff[a] <= 1'b1;
               last_ff[a] <= new_last;
            end
            OP_P2: begin
               if (a) sq2_ff <= sq2_ff - pq_ff;
               else   sq1_ff <= sq1_ff - pq_ff;
            end
            OP_P3: begin
               if (a) sq2_ff <= sq2_ff + pq_ff;
               else   sq1_ff <= sq1_ff + pq_ff;
            end
            OP_P4: cross_ff <= cross_ff - pq_ff;
            OP_P5: begin
               cross_ff <= cross_ff + pq_ff;
               if (a) begin
                  sum2_ff <= sum2_ff - {{32{old_ff[31]}}, old_ff}
                           + {{32{ret_ff[31]}}, ret_ff};
               end else begin
                  sum1_ff <= sum1_ff - {{32{old_ff[31]}}, old_ff}
                           + {{32{ret_ff[31]}}, ret_ff};
               end
               head_ff[a] <= (head_ff[a] == HEAD_LAST) ? '0 : head_ff[a] + 1'b1;
               if (fill_ff[a] != WIN_FILL) begin
                  fill_ff[a] <= fill_ff[a] + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      pq_ff <= pq_in;
      case (cmd.op)
         OP_LOAD: begin
            asset_ff <= req_tuser;
            price_ff <= req_tdata[62:0];
            time_ff  <= req_tdata[125:63];
            msb_ff   <= '0;
         end
         OP_ZERO: ret_ff <= seen_ff[a] ? 32'h80000000 : 32'd0;
         OP_MSB: begin
            if ((price_ff >> msb_cand) != '0) begin
               msb_ff <= msb_cand;
            end
         end
         OP_NORM: begin
            m_ff    <= norm_w[31:0];
            frac_ff <= '0;
         end
         OP_SQUARE: begin
            frac_ff <= {frac_ff[22:0], sq_t[32]};
            m_ff    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
         end
         OP_DIFF: begin
            diff_ff <= $signed({1'b0, cur_log}) - $signed({1'b0, last_ff[a]});
            ret_ff  <= '0;
         end
         OP_RET: ret_ff <= ret_in;
         OP_GRAB: begin
            old_ff <= (fill_ff[a] == WIN_FILL) ? own_rd : '0;
            oth_ff <= (FW'(head_ff[a]) < fill_ff[ob]) ? oth_rd : '0;
         end
         OP_DIV_LOAD: begin
            div_neg_ff <= div_src[63];
            div_num_ff <= mag64(div_src);
            div_rem_ff <= '0;
         end
         OP_DIV_STEP: begin
            div_num_ff <= div_num_in;
            div_rem_ff <= div_rem_in;
         end
         OP_DIV_STORE: begin
            case (cmd.sel)
               DIV_MEAN_FIRST:  mx_ff  <= q_clamp;
               DIV_MEAN_SECOND: my_ff  <= q_clamp;
               DIV_VAR_FIRST:   vx_ff  <= div_q;
               DIV_VAR_SECOND:  vy_ff  <= div_q;
               default:         cov_ff <= div_q;
            endcase
         end
         OP_M2: vx_ff  <= vx_ff - pq_ff;
         OP_M3: vy_ff  <= vy_ff - pq_ff;
         OP_M4: cov_ff <= cov_ff - pq_ff;
         OP_SQRT_LOAD: begin
            sq_v_ff   <= (cmd.sel == SQ_SECOND) ? vy_ff : vx_ff;
            sq_res_ff <= '0;
            sq_bit_ff <= 64'd1 << 62;
         end
         OP_SQRT_STEP: begin
            if (sq_v_ff >= sq_sum) begin
               sq_v_ff   <= sq_v_ff - sq_sum;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         OP_SQRT_STORE: begin
            if (cmd.sel == SQ_SECOND) sigy_ff <= sq_res_ff[31:0];
            else                      sigx_ff <= sq_res_ff[31:0];
         end
         OP_DMUL: begin
            d_ff    <= mul_out;
            ip_ff   <= (cov_abs >= mul_out);
            cneg_ff <= cov_ff[63];
            fr_ff   <= cov_abs;
            fq_ff   <= '0;
         end
         OP_FRAC: begin
            if (fr2 >= {1'b0, d_ff}) begin
               fr_ff <= 64'(fr2 - {1'b0, d_ff});
               fq_ff <= {fq_ff[13:0], 1'b1};
            end else begin
               fr_ff <= fr2[63:0];
               fq_ff <= {fq_ff[13:0], 1'b0};
            end
         end
         OP_EMIT: begin
            rsp_time_ff <= time_ff;
            rsp_corr_ff <= corr_val;
            rsp_dir_ff  <= !(corr_val > 16'sd0);
         end
         default: ;
      endcase
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_corr_ff, rsp_time_ff};
   assign rsp_tuser  = rsp_dir_ff;

endmodule

`default_nettype wire

[hw/rtl/rolling_return_correlation.sv]
// top level of the rolling return correlation block
`default_nettype none

// Takes price ticks of two assets, forms log returns, keeps a sliding window of
// WINDOW_LEN returns per asset and, once both windows are full, computes the Pearson
// correlation on every tick whose variances are not below the floor and emits a signal
// when it is above the high or below the low threshold. One tick is handled at a time.
// A tick of a tracked asset with a nonzero price updates its ring and sums, including
// 24 squaring steps of the log2 on the shared 32x32 multiplier; a zero price skips the
// log2 and an ignored asset skips the ring update. With both windows full there follow
// five byte-serial divisions by the window length, two bit-serial square roots and
// a 15-step fraction divide. The ring memories need no clearing pass after reset:
// entries not yet written are masked using the fill counts.
module rolling_return_correlation
   import rrc_pkg::*;
#(
   parameter int WINDOW_LEN = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // price[62:0], tick_time[125:63], zero pad
   input  wire logic [1:0]   req_tuser,   // asset[1:0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [79:0]  rsp_tdata,   // signal_time[62:0], correlation[78:63], pad
   output logic      [0:0]   rsp_tuser,   // direction[0]
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [40:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   rrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rrc_datapath #(.WINDOW_LEN(WINDOW_LEN)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
